[hw/rtl/ctp_pkg.sv]
// Shared types and constants for the control transfer TRB producer.
// Used by every module under hw/rtl; depends on nothing.
package ctp_pkg;

   localparam int RING_ENTRIES_DEFAULT = 256;

   // Addresses at or above this base are kernel virtual
   localparam logic [63:0] KERNEL_OFFSET = 64'hFFFF_FFFF_8000_0000;

   // TRB type codes, control word bits 15:10
   localparam logic [5:0] TRB_SETUP  = 6'd2;
   localparam logic [5:0] TRB_DATA   = 6'd3;
   localparam logic [5:0] TRB_STATUS = 6'd4;
   localparam logic [5:0] TRB_LINK   = 6'd6;

   // Control word flags
   localparam logic [31:0] CTRL_TOGGLE_CYCLE = 32'h0000_0002;
   localparam logic [31:0] CTRL_IOC          = 32'h0000_0020;
   localparam logic [31:0] CTRL_IDT          = 32'h0000_0040;

   // Setup stage transfer type, control word bits 17:16
   localparam logic [1:0] TRT_NO_DATA = 2'd0;
   localparam logic [1:0] TRT_OUT     = 2'd2;
   localparam logic [1:0] TRT_IN      = 2'd3;

   localparam logic [31:0] SETUP_TRB_LENGTH = 32'd8;

   typedef struct packed {
      logic [31:0] setup_low;
      logic [31:0] setup_high;
      logic [63:0] data_address;
      logic        direction_in;
      logic [7:0]  slot_number;
   } req_type;

   typedef struct packed {
      logic [7:0]  entry_index;
      logic [31:0] param_low_word;
      logic [31:0] param_high_word;
      logic [31:0] status_word;
      logic [31:0] control_word;
      logic        last_in_run;
      logic [7:0]  doorbell_slot;
   } entry_type;

endpackage

[hw/rtl/ctp_req_stage.sv]
// Request input register: holds one control request until its last beat is issued.
// Depends on ctp_pkg.
module ctp_req_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctp_pkg::req_type req_item,
   input  logic             item_pop,
   output logic             item_valid,
   output ctp_pkg::req_type item
);

   logic             held_ff;
   logic             held_in;
   ctp_pkg::req_type item_ff;

   // Take a new beat when empty or when the held request leaves this cycle
   assign req_ready = !held_ff || item_pop;

   always_comb begin
      held_in = held_ff;
      if (req_valid && req_ready) begin
         held_in = 1'b1;
      end else if (item_pop) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = held_ff;
   assign item       = item_ff;

endmodule

[hw/rtl/ctp_entry_gen.sv]
// Ring entry sequencer: keeps the write index, cycle bit and ring base, and
// forms one TRB per unstalled cycle from the held request. Depends on ctp_pkg.
module ctp_entry_gen #(
   parameter int RING_ENTRIES = ctp_pkg::RING_ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [63:0]        csr_wr_data,
   input  logic               item_valid,
   input  ctp_pkg::req_type   item,
   input  logic               beat_ready,
   output logic               beat_valid,
   output ctp_pkg::entry_type beat,
   output logic               item_pop
);

   localparam int IDX_W = $clog2(RING_ENTRIES);
   localparam logic [IDX_W-1:0] WRAP_AT  = IDX_W'(RING_ENTRIES - 3);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_ENTRIES - 1);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_STATUS = 2'd2;

   localparam logic [1:0] KIND_LINK   = 2'd0;
   localparam logic [1:0] KIND_SETUP  = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   logic [63:0]      ring_base_ff;
   logic [IDX_W-1:0] write_index_ff;
   logic [IDX_W-1:0] write_index_in;
   logic             cycle_ff;
   logic             cycle_in;
   logic [1:0]       phase_ff;
   logic [1:0]       phase_in;

   logic             fire;
   logic [1:0]       kind;
   logic [15:0]      wlength;
   logic             has_data;
   logic [1:0]       trt;
   logic             status_in_dir;
   logic [63:0]      data_addr;
   logic [63:0]      param;
   logic [31:0]      cycle_bit;
   logic [IDX_W+7:0] index_ext;

   assign wlength   = item.setup_high[31:16];
   assign has_data  = (wlength != 16'd0);
   assign fire      = item_valid && beat_ready;
   assign cycle_bit = {31'd0, cycle_ff};
   assign index_ext = {8'd0, write_index_ff};

   always_comb begin
      case (phase_ff)
         PH_START:  kind = (write_index_ff >= WRAP_AT) ? KIND_LINK : KIND_SETUP;
         PH_DATA:   kind = KIND_DATA;
         PH_STATUS: kind = KIND_STATUS;
         default:   kind = KIND_STATUS;
      endcase
   end

   always_comb begin
      if (!has_data) begin
         trt = ctp_pkg::TRT_NO_DATA;
      end else if (item.direction_in) begin
         trt = ctp_pkg::TRT_IN;
      end else begin
         trt = ctp_pkg::TRT_OUT;
      end
   end

   assign status_in_dir = !has_data || !item.direction_in;
   assign data_addr     = (item.data_address >= ctp_pkg::KERNEL_OFFSET) ?
                          item.data_address - ctp_pkg::KERNEL_OFFSET : item.data_address;

   always_comb begin
      beat.entry_index   = index_ext[7:0];
      beat.status_word   = 32'd0;
      beat.last_in_run   = 1'b0;
      beat.doorbell_slot = 8'd0;
      param              = 64'd0;
      case (kind)
         KIND_LINK: begin
            param             = ring_base_ff;
            beat.control_word = (32'(ctp_pkg::TRB_LINK) << 10) | ctp_pkg::CTRL_TOGGLE_CYCLE
                                | cycle_bit;
         end
         KIND_SETUP: begin
            param             = {item.setup_high, item.setup_low};
            beat.status_word  = ctp_pkg::SETUP_TRB_LENGTH;
            beat.control_word = (32'(ctp_pkg::TRB_SETUP) << 10) | (32'(trt) << 16)
                                | ctp_pkg::CTRL_IDT | cycle_bit;
         end
         KIND_DATA: begin
            param             = data_addr;
            beat.status_word  = {16'd0, wlength};
            beat.control_word = (32'(ctp_pkg::TRB_DATA) << 10)
                                | (32'(item.direction_in) << 16) | cycle_bit;
         end
         default: begin
            beat.last_in_run   = 1'b1;
            beat.doorbell_slot = item.slot_number;
            beat.control_word  = (32'(ctp_pkg::TRB_STATUS) << 10)
                                 | (32'(status_in_dir) << 16) | ctp_pkg::CTRL_IOC | cycle_bit;
         end
      endcase
      beat.param_low_word  = param[31:0];
      beat.param_high_word = param[63:32];
   end

   assign beat_valid = item_valid;
   assign item_pop   = fire && (kind == KIND_STATUS);

   always_comb begin
      write_index_in = write_index_ff;
      cycle_in       = cycle_ff;
      phase_in       = phase_ff;
      if (fire) begin
         case (kind)
            KIND_LINK: begin
               // wrap and flip; stay in start, the setup entry follows
               write_index_in = '0;
               cycle_in       = !cycle_ff;
            end
            KIND_SETUP: begin
               write_index_in = write_index_ff + IDX_ONE;
               phase_in       = has_data ? PH_DATA : PH_STATUS;
            end
            KIND_DATA: begin
               write_index_in = write_index_ff + IDX_ONE;
               phase_in       = PH_STATUS;
            end
            default: begin
               write_index_in = write_index_ff + IDX_ONE;
               phase_in       = PH_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         cycle_ff       <= 1'b1;
         phase_ff       <= PH_START;
         ring_base_ff   <= 64'd0;
      end else begin
         write_index_ff <= write_index_in;
         cycle_ff       <= cycle_in;
         phase_ff       <= phase_in;
         if (csr_wr_en) begin
            ring_base_ff <= csr_wr_data;
         end
      end
   end

`ifndef ASSERT_OFF
   a_index_in_ring: assert property (@(posedge clock) disable iff (reset)
      write_index_ff <= LAST_IDX)
      else $error("write index past ring end");

   a_link_wraps: assert property (@(posedge clock) disable iff (reset)
      fire && (kind == KIND_LINK) |=> (write_index_ff == '0) && (cycle_ff != $past(cycle_ff)))
      else $error("link entry did not wrap index and flip cycle");

   a_data_needs_length: assert property (@(posedge clock) disable iff (reset)
      fire && (kind == KIND_DATA) |-> has_data)
      else $error("data entry issued with zero wLength");

   a_setup_not_last: assert property (@(posedge clock) disable iff (reset)
      fire && (kind == KIND_SETUP) |=> (phase_ff != PH_START) && item_valid)
      else $error("request left before its status entry");
`endif

endmodule

[hw/rtl/ctp_rsp_stage.sv]
// Result output register: holds one ring entry beat until the consumer takes it.
// Depends on ctp_pkg.
module ctp_rsp_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               beat_valid,
   input  ctp_pkg::entry_type beat,
   output logic               beat_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ctp_pkg::entry_type rsp_entry
);

   logic               valid_ff;
   logic               valid_in;
   ctp_pkg::entry_type entry_ff;

   // Load when empty or when the current beat drains this cycle
   assign beat_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (beat_valid && beat_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_valid && beat_ready) begin
         entry_ff <= beat;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_entry = entry_ff;

endmodule

[hw/rtl/control_transfer_trb_producer_unit.sv]
// Top level of the control transfer TRB producer for an endpoint-0 transfer ring.
// Depends on ctp_pkg, ctp_req_stage, ctp_entry_gen and ctp_rsp_stage.
//
//   channel | ports  | dir | contents
//   --------+--------+-----+---------------------------------------------
//   request | req_*  | in  | setup words, data address, direction, slot
//   result  | rsp_*  | out | one TRB per beat, doorbell on the last beat
//   config  | csr_*  | in  | ring base address, written on csr_wr_en
//
// A request yields two to four result beats (link if near the ring end, setup,
// data if wLength is nonzero, status), one beat per cycle into the output register
// when rsp_ready does not stall it.
// The first beat is formed from the held request and then registered for output.
// Synchronous reset clears the write index to 0 and sets the cycle bit.
// A stalled rsp_ready holds the current beat and, once the request register is
// busy, deasserts req_ready.
module control_transfer_trb_producer_unit #(
   parameter int RING_ENTRIES = ctp_pkg::RING_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_setup_low,
   input  logic [31:0] req_setup_high,
   input  logic [63:0] req_data_address,
   input  logic        req_direction_in,
   input  logic [7:0]  req_slot_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_entry_index,
   output logic [31:0] rsp_param_low_word,
   output logic [31:0] rsp_param_high_word,
   output logic [31:0] rsp_status_word,
   output logic [31:0] rsp_control_word,
   output logic        rsp_last_in_run,
   output logic [7:0]  rsp_doorbell_slot
);

   ctp_pkg::req_type   req_item;
   ctp_pkg::req_type   item;
   ctp_pkg::entry_type beat;
   ctp_pkg::entry_type rsp_entry;
   logic               item_valid;
   logic               item_pop;
   logic               beat_valid;
   logic               beat_ready;

   assign req_item.setup_low    = req_setup_low;
   assign req_item.setup_high   = req_setup_high;
   assign req_item.data_address = req_data_address;
   assign req_item.direction_in = req_direction_in;
   assign req_item.slot_number  = req_slot_number;

   ctp_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_pop   (item_pop),
      .item_valid (item_valid),
      .item       (item)
   );

   ctp_entry_gen #(
      .RING_ENTRIES (RING_ENTRIES)
   ) u_entry_gen (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .beat_ready  (beat_ready),
      .beat_valid  (beat_valid),
      .beat        (beat),
      .item_pop    (item_pop)
   );

   ctp_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_entry  (rsp_entry)
   );

   assign rsp_entry_index     = rsp_entry.entry_index;
   assign rsp_param_low_word  = rsp_entry.param_low_word;
   assign rsp_param_high_word = rsp_entry.param_high_word;
   assign rsp_status_word     = rsp_entry.status_word;
   assign rsp_control_word    = rsp_entry.control_word;
   assign rsp_last_in_run     = rsp_entry.last_in_run;
   assign rsp_doorbell_slot   = rsp_entry.doorbell_slot;

endmodule

[tb/tb_top.sv]
// Self-checking bench for control_transfer_trb_producer_unit: drives control
// requests and ring base writes, predicts every ring entry and checks each beat.
// Depends on ctp_pkg and the producer RTL.
module tb_top;

   localparam int RING_SIZE = ctp_pkg::RING_ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [31:0] DIR_IN_FLAG = 32'h0001_0000;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_setup_low = '0;
   logic [31:0] req_setup_high = '0;
   logic [63:0] req_data_address = '0;
   logic        req_direction_in = 1'b0;
   logic [7:0]  req_slot_number = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [7:0]  rsp_entry_index;
   logic [31:0] rsp_param_low_word;
   logic [31:0] rsp_param_high_word;
   logic [31:0] rsp_status_word;
   logic [31:0] rsp_control_word;
   logic        rsp_last_in_run;
   logic [7:0]  rsp_doorbell_slot;

   // Predicted ring state
   int                 ring_pos = 0;
   logic               cycle_bit = 1'b1;
   logic [63:0]        ring_base = '0;
   ctp_pkg::entry_type pending_entries[$];

   bit quiet = 1'b0;
   int burst_left = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int entries_checked = 0;
   int requests_sent = 0;
   int ring_wraps = 0;
   int data_stages = 0;
   int kernel_hits = 0;

   control_transfer_trb_producer_unit #(.RING_ENTRIES(RING_SIZE)) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_setup_low(req_setup_low),
      .req_setup_high(req_setup_high),
      .req_data_address(req_data_address),
      .req_direction_in(req_direction_in),
      .req_slot_number(req_slot_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_entry_index(rsp_entry_index),
      .rsp_param_low_word(rsp_param_low_word),
      .rsp_param_high_word(rsp_param_high_word),
      .rsp_status_word(rsp_status_word),
      .rsp_control_word(rsp_control_word),
      .rsp_last_in_run(rsp_last_in_run),
      .rsp_doorbell_slot(rsp_doorbell_slot)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d entries outstanding", cycle_count,
                  pending_entries.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result sink: random stalls unless in a quiet stretch
   always @(negedge clock) begin
      if (reset || quiet) begin
         hold_left = 0;
         rsp_ready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         hold_left = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic ctp_pkg::entry_type make_entry(int pos, logic [63:0] param,
                                                     logic [31:0] status,
                                                     logic [31:0] control, logic last,
                                                     logic [7:0] slot);
      ctp_pkg::entry_type e;
      e.entry_index     = pos[7:0];
      e.param_low_word  = param[31:0];
      e.param_high_word = param[63:32];
      e.status_word     = status;
      e.control_word    = control;
      e.last_in_run     = last;
      e.doorbell_slot   = last ? slot : 8'd0;
      return e;
   endfunction

   // Work out the ring entries one request writes and advance the ring state
   function automatic void predict_request(ctp_pkg::req_type r);
      logic [15:0] wlen;
      logic [1:0]  trt;
      logic [63:0] addr;
      logic        status_in;
      wlen = r.setup_high[31:16];
      if (ring_pos >= RING_SIZE) ring_pos = 0;
      if (ring_pos + 3 > RING_SIZE - 1) begin
         pending_entries.push_back(make_entry(ring_pos, ring_base, 32'd0,
            (32'(ctp_pkg::TRB_LINK) << 10) | ctp_pkg::CTRL_TOGGLE_CYCLE | 32'(cycle_bit),
            1'b0, 8'd0));
         ring_pos = 0;
         cycle_bit = ~cycle_bit;
         ring_wraps++;
      end
      if (wlen == 0) trt = ctp_pkg::TRT_NO_DATA;
      else trt = r.direction_in ? ctp_pkg::TRT_IN : ctp_pkg::TRT_OUT;
      pending_entries.push_back(make_entry(ring_pos, {r.setup_high, r.setup_low},
         ctp_pkg::SETUP_TRB_LENGTH,
         (32'(ctp_pkg::TRB_SETUP) << 10) | (32'(trt) << 16) | ctp_pkg::CTRL_IDT |
         32'(cycle_bit), 1'b0, 8'd0));
      ring_pos++;
      if (wlen != 0) begin
         addr = r.data_address;
         if (addr >= ctp_pkg::KERNEL_OFFSET) begin
            addr -= ctp_pkg::KERNEL_OFFSET;
            kernel_hits++;
         end
         pending_entries.push_back(make_entry(ring_pos, addr, 32'(wlen),
            (32'(ctp_pkg::TRB_DATA) << 10) | (r.direction_in ? DIR_IN_FLAG : 32'd0) |
            32'(cycle_bit), 1'b0, 8'd0));
         ring_pos++;
         data_stages++;
      end
      // Status stage runs IN whenever there is no data stage
      status_in = (wlen == 0) || !r.direction_in;
      pending_entries.push_back(make_entry(ring_pos, 64'd0, 32'd0,
         (32'(ctp_pkg::TRB_STATUS) << 10) | (status_in ? DIR_IN_FLAG : 32'd0) |
         ctp_pkg::CTRL_IOC | 32'(cycle_bit), 1'b1, r.slot_number));
      ring_pos++;
      requests_sent++;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Check every result beat against the oldest predicted entry
   always @(posedge clock) begin
      ctp_pkg::entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_entries.size() == 0) begin
            $error("unexpected entry beat at index %0d", rsp_entry_index);
            mismatch_count++;
         end else begin
            want = pending_entries.pop_front();
            compare_field("entry_index", 64'(want.entry_index), 64'(rsp_entry_index));
            compare_field("param_low_word", 64'(want.param_low_word),
                          64'(rsp_param_low_word));
            compare_field("param_high_word", 64'(want.param_high_word),
                          64'(rsp_param_high_word));
            compare_field("status_word", 64'(want.status_word), 64'(rsp_status_word));
            compare_field("control_word", 64'(want.control_word), 64'(rsp_control_word));
            compare_field("last_in_run", 64'(want.last_in_run), 64'(rsp_last_in_run));
            compare_field("doorbell_slot", 64'(want.doorbell_slot),
                          64'(rsp_doorbell_slot));
            entries_checked++;
         end
      end
   end

   function automatic ctp_pkg::req_type build_request(logic [31:0] sl, logic [31:0] sh,
                                                      logic [63:0] addr, logic dir,
                                                      logic [7:0] slot);
      ctp_pkg::req_type r;
      r.setup_low    = sl;
      r.setup_high   = sh;
      r.data_address = addr;
      r.direction_in = dir;
      r.slot_number  = slot;
      return r;
   endfunction

   task automatic send_request(input ctp_pkg::req_type r);
      int gap;
      if (!quiet && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_setup_low    <= r.setup_low;
      req_setup_high   <= r.setup_high;
      req_data_address <= r.data_address;
      req_direction_in <= r.direction_in;
      req_slot_number  <= r.slot_number;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
   endtask

   // Drop valid and wait for every predicted entry to drain
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_ring_base(input logic [63:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ring_base = value;
   endtask

   task automatic test_no_data_stage();
      send_request(build_request(32'h0000_0000, 32'h0000_0000, 64'h0, 1'b0, 8'h01));
      send_request(build_request(32'hFFFF_FFFF, 32'h0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                 1'b1, 8'h02));
      send_request(build_request(32'hA5A5_5A5A, 32'h0000_1234, 64'h1000, 1'b0, 8'h03));
      send_request(build_request(32'h0123_4567, 32'h0000_8000, 64'h2000, 1'b1, 8'h04));
   endtask

   task automatic test_data_stage();
      send_request(build_request(32'h0000_0680, 32'h0001_0000, 64'h0000_0000_1234_5678,
                                 1'b1, 8'h10));
      send_request(build_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0000_0001_0000_0000,
                                 1'b0, 8'h11));
      send_request(build_request(32'h0000_0009, 32'hFFFF_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                 1'b1, 8'h12));
      send_request(build_request(32'h5555_AAAA, 32'h0040_00FF, 64'h0, 1'b0, 8'h13));
   endtask

   task automatic test_kernel_address();
      send_request(build_request(32'h1, 32'h0008_0000, ctp_pkg::KERNEL_OFFSET - 64'd1,
                                 1'b1, 8'h20));
      send_request(build_request(32'h2, 32'h0008_0000, ctp_pkg::KERNEL_OFFSET, 1'b0,
                                 8'h21));
      send_request(build_request(32'h3, 32'h0008_0000, ctp_pkg::KERNEL_OFFSET + 64'd1,
                                 1'b1, 8'h22));
      send_request(build_request(32'h4, 32'h0008_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                                 8'h23));
      send_request(build_request(32'h5, 32'h0008_0000, 64'h0, 1'b1, 8'h24));
   endtask

   task automatic test_slot_extremes();
      send_request(build_request($urandom, 32'h0002_0000, 64'h8000, 1'b1, 8'h00));
      send_request(build_request($urandom, 32'h0000_0000, 64'h8000, 1'b0, 8'hFF));
   endtask

   function automatic ctp_pkg::req_type random_request();
      ctp_pkg::req_type r;
      r.setup_low    = $urandom;
      r.setup_high   = $urandom;
      r.direction_in = 1'($urandom_range(0, 1));
      r.slot_number  = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0, 1: r.setup_high[31:16] = 16'd0;
         2:    r.setup_high[31:16] = 16'($urandom_range(1, 64));
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: r.data_address = ctp_pkg::KERNEL_OFFSET + 64'($urandom_range(0, 15));
         1: r.data_address = ctp_pkg::KERNEL_OFFSET - 64'($urandom_range(1, 16));
         2: r.data_address = {32'hFFFF_FFFF, 1'b1, 31'($urandom)};
         default: r.data_address = {$urandom, $urandom};
      endcase
      return r;
   endfunction

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         // Hold quiet stretches with no gaps or stalls between busy ones
         quiet = (i % 50) < 12;
         send_request(random_request());
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_ring_base(64'hFFFF_FFFF_FFFF_FFFF);
      test_no_data_stage();
      test_data_stage();
      test_kernel_address();
      test_slot_extremes();

      set_ring_base(64'h0);
      test_random_traffic(155);
      set_ring_base({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFF0);
      test_random_traffic(155);
      set_ring_base(64'h8000_0000_0000_0000);
      test_random_traffic(155);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Sent %0d control requests, checked %0d ring entries", requests_sent,
               entries_checked);
      $display("Saw %0d ring wraps, %0d data stages, %0d kernel addresses, %0d mismatches",
               ring_wraps, data_stages, kernel_hits, mismatch_count);
      if (mismatch_count == 0 && pending_entries.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
